FILE: src/coo_coordinate_reshape_macros.svh
// ----------------------------------------------------------------------------
// coo_coordinate_reshape_macros
// Assertion macros shared by the reshape block.
// ----------------------------------------------------------------------------
`ifndef COO_COORDINATE_RESHAPE_MACROS_SVH
`define COO_COORDINATE_RESHAPE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define COO_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Invariant checked at every rising clock edge outside reset.
`define COO_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

`endif

FILE: src/coo_pkg.sv
// ----------------------------------------------------------------------------
// coo_pkg
// Types, constants and helpers for the COO coordinate reshape block.
// ----------------------------------------------------------------------------
`default_nettype none

package coo_pkg;

	localparam int MAX_RANK     = 8;
	localparam int EXTENT_WIDTH = 16;
	localparam int FLAT_WIDTH   = 32;
	localparam int RANK_W       = 4;
	localparam int EXT_BUS_W    = MAX_RANK * EXTENT_WIDTH;
	localparam int TOT_W        = FLAT_WIDTH + 1;
	localparam int PROD_W       = TOT_W + EXTENT_WIDTH;
	localparam int DIV_STEPS    = 4;
	localparam int DIV_SUBS     = FLAT_WIDTH / DIV_STEPS;
	localparam int FLAT_STAGES  = MAX_RANK;
	localparam int STATUS_STAGE = FLAT_STAGES;
	localparam int DIV_FIRST    = STATUS_STAGE + 1;
	localparam int N_STAGES     = DIV_FIRST + MAX_RANK * DIV_SUBS;

	localparam logic [TOT_W-1:0] FLAT_LIMIT = TOT_W'(1) << FLAT_WIDTH;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_OLD_RANK   = 3'd0,
		REG_NEW_RANK   = 3'd1,
		REG_OLD_EXT_LO = 3'd2,
		REG_OLD_EXT_HI = 3'd3,
		REG_NEW_EXT_LO = 3'd4,
		REG_NEW_EXT_HI = 3'd5
	} cfg_reg_t;

	// Status codes of a result.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// Configuration seen by the datapath; ranks are already clamped.
	typedef struct packed {
		logic [RANK_W-1:0]    orank;
		logic [RANK_W-1:0]    nrank;
		logic [EXT_BUS_W-1:0] old_ext;
		logic [EXT_BUS_W-1:0] new_ext;
	} cfg_t;

	// One pipeline slot.
	typedef struct packed {
		logic [MAX_RANK-1:0][EXTENT_WIDTH-1:0] coord;
		logic [63:0]                           value;
		logic                                  last;
		status_t                               status;
		logic [FLAT_WIDTH-1:0]                 flat;
		logic [EXTENT_WIDTH-1:0]               rem;
		logic [TOT_W-1:0]                      otot;
		logic [TOT_W-1:0]                      ntot;
	} item_t;

	// Extent of dimension d from a packed extent bus.
	function automatic logic [EXTENT_WIDTH-1:0] ext_of(input logic [EXT_BUS_W-1:0] ext,
		input int d);
		return ext[d*EXTENT_WIDTH +: EXTENT_WIDTH];
	endfunction

	// Running total times one extent, capped at the flat limit.
	function automatic logic [TOT_W-1:0] tot_mul(input logic [TOT_W-1:0] p,
		input logic [EXTENT_WIDTH-1:0] e);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(p) * PROD_W'(e);
		return (prod > PROD_W'(FLAT_LIMIT)) ? FLAT_LIMIT : prod[TOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/coo_cfg_regs.sv
// ----------------------------------------------------------------------------
// coo_cfg_regs
// Configuration register file: ranks and extents of both shapes.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_cfg_regs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	output coo_pkg::cfg_t    cfg
);

	localparam logic [63:0] EXT_RESET = 64'h0001_0001_0001_0001;

	logic [coo_pkg::RANK_W-1:0] orank_q, nrank_q;
	logic [63:0]                old_lo_q, old_hi_q, new_lo_q, new_hi_q;
	logic [coo_pkg::RANK_W-1:0] rank_wr;

	// Rank values (low four bits of the write data) above the maximum are stored as the maximum.
	assign rank_wr = (cfg_wdata[3:0] > 4'(coo_pkg::MAX_RANK)) ?
		4'(coo_pkg::MAX_RANK) : cfg_wdata[3:0];

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orank_q  <= 4'd1;
			nrank_q  <= 4'd1;
			old_lo_q <= EXT_RESET;
			old_hi_q <= EXT_RESET;
			new_lo_q <= EXT_RESET;
			new_hi_q <= EXT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				coo_pkg::REG_OLD_RANK:   orank_q  <= rank_wr;
				coo_pkg::REG_NEW_RANK:   nrank_q  <= rank_wr;
				coo_pkg::REG_OLD_EXT_LO: old_lo_q <= cfg_wdata;
				coo_pkg::REG_OLD_EXT_HI: old_hi_q <= cfg_wdata;
				coo_pkg::REG_NEW_EXT_LO: new_lo_q <= cfg_wdata;
				coo_pkg::REG_NEW_EXT_HI: new_hi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.orank   = orank_q;
	assign cfg.nrank   = nrank_q;
	assign cfg.old_ext = {old_hi_q, old_lo_q};
	assign cfg.new_ext = {new_hi_q, new_lo_q};

endmodule

`default_nettype wire

FILE: src/coo_coordinate_reshape.sv
// One result per input entry; the whole pipeline halts on a stall.
// Throughput: one entry per cycle; ravel stages after the first hold a 32x16
// multiply, and division stages hold four restoring-division steps each.
// Reset clears all valid bits and sets both ranks to 1 and all extents to 1.
// ----------------------------------------------------------------------------
// coo_coordinate_reshape
// Row-major ravel of old COO coordinates and unravel into the new shape.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_coordinate_reshape (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// old_coord_0 .. old_coord_7 (16 bits each), value_bits (64)
	input  wire logic [191:0] s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// new_coord_0 .. new_coord_7 (16 bits each), value_out (64)
	output logic [191:0]      m_tdata,
	output logic              m_tlast,
	// status (2)
	output logic [1:0]        m_tuser
);

	localparam int NST = coo_pkg::N_STAGES;

	coo_pkg::cfg_t  cfg;
	coo_pkg::item_t pipe_s [NST];
	coo_pkg::item_t nxt    [NST];
	logic [NST-1:0] vld_s;
	logic           en;

	coo_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// The pipeline advances as a whole whenever the output slot can move.
	assign en       = !vld_s[NST-1] || m_tready;
	assign s_tready = en;

	// Next content of every stage.
	always_comb begin
		logic [coo_pkg::EXTENT_WIDTH-1:0] e;
		logic [coo_pkg::EXTENT_WIDTH:0]   t;
		logic                             act;
		int                               dim;
		int                               sub;
		coo_pkg::item_t                   it;
		e   = '0;
		t   = '0;
		act = 1'b0;
		dim = 0;
		sub = 0;
		it  = '0;
		for (int k = 0; k < NST; k++) begin
			if (k == 0) begin
				// Capture the entry and start ravel and totals at dimension 0.
				it        = '0;
				it.coord  = s_tdata[127:0];
				it.value  = s_tdata[191:128];
				it.last   = s_tlast;
				it.status = coo_pkg::ST_OK;
				it.otot   = 33'd1;
				it.ntot   = 33'd1;
				if (cfg.orank != 4'd0) begin
					it.flat = 32'(it.coord[0]);
					it.otot = 33'(coo_pkg::ext_of(cfg.old_ext, 0));
				end
				if (cfg.nrank != 4'd0)
					it.ntot = 33'(coo_pkg::ext_of(cfg.new_ext, 0));
			end else if (k < coo_pkg::FLAT_STAGES) begin
				// One Horner step of the ravel and one factor of each total.
				it = pipe_s[k-1];
				if (4'(k) < cfg.orank) begin
					e       = coo_pkg::ext_of(cfg.old_ext, k);
					it.flat = 32'(it.flat * 32'(e)) + 32'(it.coord[k]);
					it.otot = coo_pkg::tot_mul(it.otot, e);
				end
				if (4'(k) < cfg.nrank)
					it.ntot = coo_pkg::tot_mul(it.ntot, coo_pkg::ext_of(cfg.new_ext, k));
			end else if (k == coo_pkg::STATUS_STAGE) begin
				// Compare the totals and clear the coordinate slots.
				it       = pipe_s[k-1];
				it.coord = '0;
				if (it.otot >= coo_pkg::FLAT_LIMIT || it.ntot >= coo_pkg::FLAT_LIMIT)
					it.status = coo_pkg::ST_OVERFLOW;
				else if (it.otot != it.ntot)
					it.status = coo_pkg::ST_MISMATCH;
				else
					it.status = coo_pkg::ST_OK;
			end else begin
				// Four restoring-division steps, last dimension first.
				it  = pipe_s[k-1];
				dim = coo_pkg::MAX_RANK - 1 - (k - coo_pkg::DIV_FIRST) / coo_pkg::DIV_SUBS;
				sub = (k - coo_pkg::DIV_FIRST) % coo_pkg::DIV_SUBS;
				e   = coo_pkg::ext_of(cfg.new_ext, dim);
				act = (4'(dim) < cfg.nrank) && (e != '0) && (it.status == coo_pkg::ST_OK);
				if (sub == 0)
					it.rem = '0;
				if (act) begin
					for (int i = 0; i < coo_pkg::DIV_STEPS; i++) begin
						t = {it.rem, it.flat[coo_pkg::FLAT_WIDTH-1]};
						if (t >= {1'b0, e}) begin
							it.rem  = 16'(t - {1'b0, e});
							it.flat = {it.flat[coo_pkg::FLAT_WIDTH-2:0], 1'b1};
						end else begin
							it.rem  = t[coo_pkg::EXTENT_WIDTH-1:0];
							it.flat = {it.flat[coo_pkg::FLAT_WIDTH-2:0], 1'b0};
						end
					end
					if (sub == coo_pkg::DIV_SUBS - 1)
						it.coord[dim] = it.rem;
				end
			end
			nxt[k] = it;
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], s_tvalid};
		end
	end

	// Payload of the stages.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NST; k++)
				pipe_s[k] <= nxt[k];
		end
	end

	assign m_tvalid = vld_s[NST-1];
	assign m_tdata  = {pipe_s[NST-1].value, pipe_s[NST-1].coord};
	assign m_tlast  = pipe_s[NST-1].last;
	assign m_tuser  = pipe_s[NST-1].status;

`include "coo_coordinate_reshape_macros.svh"

	`COO_ASSERT_IMPL(a_err_zero, m_tvalid && m_tuser != coo_pkg::ST_OK, m_tdata[127:0] == '0, "error result carries nonzero coordinates")
	`COO_ASSERT_IMPL(a_status_code, m_tvalid, m_tuser != 2'd3, "undefined status code")
	`COO_ASSERT_ALWAYS(a_ready, s_tready == (!m_tvalid || m_tready), "input ready disagrees with output stall")

endmodule

`default_nettype wire
